/* src/rotary_position_rotate_top_assert.svh */
// Assertion macros shared by the rotary position rotate RTL.
`ifndef ROTARY_POSITION_ROTATE_TOP_ASSERT_SVH
`define ROTARY_POSITION_ROTATE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define RPR_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RPR_ASSERT(lbl, clk, rst, prop)
`define RPR_ASSERT_NR(lbl, clk, prop)
`endif
`endif

/* src/rpr_pkg.sv */
// Types, constants and constant functions of the rotary position rotate block.
`timescale 1ns / 1ps
package rpr_pkg;

  localparam int EXP_BITS = 24;
  localparam int VW = 44;
  localparam int ZW = 34;
  localparam logic [29:0] INV_TWO_PI = 30'h28BE60DC;
  localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [5:0]         pair_index;
    logic [15:0]        position;
    logic signed [31:0] x_first;
    logic signed [31:0] x_second;
  } in_t;

  typedef struct packed {
    logic signed [31:0] y_first;
    logic signed [31:0] y_second;
    logic               clipped;
  } out_t;

  typedef struct packed {
    logic [6:0]  rotary_pairs;
    logic [27:0] freq_log2_step;
    logic [23:0] inv_pos_scale;
  } cfg_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // Bitwise integer square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] w;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    w = v;
    for (int i = 0; i < 32; i++) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q0.32 value of 2^(-2^-k): repeated square roots starting from sqrt(1/2).
  function automatic logic [31:0] root_const(input int k);
    logic [63:0] c;
    c = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 1; j < k; j++) begin
      c = isqrt64({c[31:0], 32'h0});
    end
    return c[31:0];
  endfunction

endpackage

/* src/rpr_cfg.sv */
// APB register file holding the rotary configuration.
`timescale 1ns / 1ps
`include "rotary_position_rotate_top_assert.svh"
module rpr_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rpr_pkg::cfg_t cfg
);
  import rpr_pkg::*;

  localparam logic [1:0] REG_ROTARY_PAIRS = 2'd0;
  localparam logic [1:0] REG_FREQ_STEP    = 2'd1;
  localparam logic [1:0] REG_POS_SCALE    = 2'd2;

  logic wr;
  logic wr_step;
  logic wr_scale;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign wr_step  = wr && (paddr[3:2] == REG_FREQ_STEP);
  assign wr_scale = wr && (paddr[3:2] == REG_POS_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotary_pairs   <= 7'd64;
      cfg.freq_log2_step <= 28'd3483400;
      cfg.inv_pos_scale  <= 24'd65536;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_ROTARY_PAIRS: cfg.rotary_pairs   <= pwdata[6:0];
        REG_FREQ_STEP:    cfg.freq_log2_step <= pwdata[27:0];
        REG_POS_SCALE:    cfg.inv_pos_scale  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROTARY_PAIRS: prdata = {25'h0, cfg.rotary_pairs};
      REG_FREQ_STEP:    prdata = {4'h0, cfg.freq_log2_step};
      REG_POS_SCALE:    prdata = {8'h0, cfg.inv_pos_scale};
      default:          prdata = 32'h0;
    endcase
  end

  `RPR_ASSERT(a_pairs_write, clk, rst, (wr && paddr[3:2] == REG_ROTARY_PAIRS) |=> (cfg.rotary_pairs == $past(pwdata[6:0])))
  `RPR_ASSERT(a_step_write, clk, rst, wr_step |=> (cfg.freq_log2_step == $past(pwdata[27:0])))
  `RPR_ASSERT(a_scale_write, clk, rst, wr_scale |=> (cfg.inv_pos_scale == $past(pwdata[23:0])))
endmodule

/* src/rpr_root_cell.sv */
// One cell of the frequency chain: multiplies by a fixed root when its exponent bit is set.
`timescale 1ns / 1ps
module rpr_root_cell #(
  parameter int K = 1
) (
  input  logic        clk,
  input  logic        en,
  input  logic [32:0] m_in,
  input  logic [23:0] f_in,
  output logic [32:0] m_out,
  output logic [23:0] f_out
);
  import rpr_pkg::*;

  localparam logic [31:0] C = root_const(K);

  logic [64:0] prod;

  assign prod = m_in * C;

  always_ff @(posedge clk) begin
    if (en) begin
      f_out <= f_in;
      if (f_in[EXP_BITS-K]) begin
        m_out <= prod[64:32];
      end else begin
        m_out <= m_in;
      end
    end
  end
endmodule

/* src/rpr_cordic_cell.sv */
// One rotation cell of the CORDIC chain.
`timescale 1ns / 1ps
module rpr_cordic_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            en,
  input  rpr_pkg::cord_t  d_in,
  output rpr_pkg::cord_t  d_out
);
  import rpr_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'({2'b00, ATAN_TURNS[K]});

  logic signed [VW-1:0] dx;
  logic signed [VW-1:0] dy;

  assign dx = d_in.y >>> K;
  assign dy = d_in.x >>> K;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!d_in.z[ZW-1]) begin
        d_out.x <= d_in.x - dx;
        d_out.y <= d_in.y + dy;
        d_out.z <= d_in.z - ATAN;
      end else begin
        d_out.x <= d_in.x + dx;
        d_out.y <= d_in.y - dy;
        d_out.z <= d_in.z + ATAN;
      end
    end
  end
endmodule

/* src/rotary_position_rotate_top.sv */
// Top level of the rotary position rotate block: angle pipeline, CORDIC chain, output.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// only while a finished item waits in the output register and out_ready is low.
// Reset (synchronous, rst high) empties the pipeline and loads the register defaults
// 64, 3483400 and 65536. No memory needs clearing.
`timescale 1ns / 1ps
`include "rotary_position_rotate_top_assert.svh"
module rotary_position_rotate_top #(
  parameter int VEC_CHANNELS  = 128,
  parameter int POS_BITS      = 16,
  parameter int CORDIC_STAGES = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rpr_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rpr_pkg::*;

  localparam int HALF = VEC_CHANNELS / 2;
  localparam int PB   = (POS_BITS < 16) ? POS_BITS : 16;
  // Pipeline depth before the output register: input stage, root chain,
  // four angle stages, CORDIC chain.
  localparam int D    = 1 + EXP_BITS + 4 + CORDIC_STAGES;

  typedef struct packed {
    logic               pass;
    logic signed [31:0] xa;
    logic signed [31:0] xb;
  } side_t;

  typedef struct packed {
    logic [39:0]        p;
    logic [9:0]         n;
    logic signed [39:0] vx;
    logic signed [39:0] vy;
  } mside_t;

  cfg_t cfg;

  rpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The whole row advances whenever the output register can take an item.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [D-1:0] vl;
  side_t        sd [D];

  // Input stage: exponent, scaled position, gain prescale and pass decision.
  logic [15:0]        pos_m;
  logic [10:0]        limit;
  logic signed [64:0] px;
  logic signed [64:0] py;
  logic [33:0]        e0;
  logic [39:0]        p0;
  logic signed [39:0] vx0;
  logic signed [39:0] vy0;

  assign pos_m = in_data.position & 16'((32'd1 << PB) - 1);
  assign limit = ({4'h0, cfg.rotary_pairs} > 11'(HALF)) ? 11'(HALF)
                                                      : {4'h0, cfg.rotary_pairs};
  assign px = in_data.x_first * $signed({1'b0, CORDIC_GAIN});
  assign py = in_data.x_second * $signed({1'b0, CORDIC_GAIN});

  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl <= {vl[D-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0       <= in_data.pair_index * cfg.freq_log2_step;
      p0       <= pos_m * cfg.inv_pos_scale;
      vx0      <= px[63:24];
      vy0      <= py[63:24];
      sd[0].pass <= ({5'h0, in_data.pair_index} >= limit);
      sd[0].xa   <= in_data.x_first;
      sd[0].xb   <= in_data.x_second;
      for (int i = 1; i < D; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // Root chain: one cell per fraction bit of the exponent builds 2^-frac.
  logic [32:0] mc_m [EXP_BITS+1];
  logic [23:0] mc_f [EXP_BITS+1];
  mside_t      msd  [EXP_BITS];

  assign mc_m[0] = 33'h1_0000_0000;
  assign mc_f[0] = e0[23:0];

  for (genvar k = 1; k <= EXP_BITS; k++) begin : g_root
    rpr_root_cell #(.K(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .m_in  (mc_m[k-1]),
      .f_in  (mc_f[k-1]),
      .m_out (mc_m[k]),
      .f_out (mc_f[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      msd[0] <= '{p: p0, n: e0[33:24], vx: vx0, vy: vy0};
      for (int i = 1; i < EXP_BITS; i++) begin
        msd[i] <= msd[i-1];
      end
    end
  end

  // Angle stages: radians = p*m >> (24+n), then turns = radians / (2*pi).
  logic [64:0]        plo;
  logic [40:0]        phi;
  logic [10:0]        sh;
  logic signed [39:0] vx1, vy1, vx2, vy2, vx3, vy3;
  logic [72:0]        prod;
  logic [72:0]        prod_sh;
  logic [48:0]        rad;
  logic [61:0]        alo;
  logic [46:0]        ahi;
  logic [31:0]        ang;
  logic [31:0]        ang_f;
  logic               fold;
  logic signed [VW-1:0] vxe;
  logic signed [VW-1:0] vye;

  assign prod    = {phi, 32'h0} + {8'h0, plo};
  assign prod_sh = prod >> sh;
  assign ang     = 32'(alo >> 24) + {ahi[23:0], 8'h0};
  // Second and third quadrants are folded by a half turn with both inputs negated.
  assign fold    = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
  assign ang_f   = fold ? {~ang[31], ang[30:0]} : ang;
  assign vxe     = VW'(vx3);
  assign vye     = VW'(vy3);

  cord_t cc [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      plo <= msd[EXP_BITS-1].p[31:0] * mc_m[EXP_BITS];
      phi <= msd[EXP_BITS-1].p[39:32] * mc_m[EXP_BITS];
      sh  <= {1'b0, msd[EXP_BITS-1].n} + 11'd24;
      vx1 <= msd[EXP_BITS-1].vx;
      vy1 <= msd[EXP_BITS-1].vy;

      rad <= (sh >= 11'd73) ? 49'h0 : prod_sh[48:0];
      vx2 <= vx1;
      vy2 <= vy1;

      alo <= rad[31:0] * INV_TWO_PI;
      ahi <= rad[48:32] * INV_TWO_PI;
      vx3 <= vx2;
      vy3 <= vy2;

      cc[0].x <= fold ? -vxe : vxe;
      cc[0].y <= fold ? -vye : vye;
      cc[0].z <= ZW'($signed(ang_f));
    end
  end

  // CORDIC chain: one cell per rotation step.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    rpr_cordic_cell #(.K(k)) u_cell (
      .clk   (clk),
      .en    (en),
      .d_in  (cc[k]),
      .d_out (cc[k+1])
    );
  end

  // Round to Q16.16 and saturate; pass-through items bypass the arithmetic.
  logic signed [VW-1:0] rx_s;
  logic signed [VW-1:0] ry_s;
  logic signed [35:0]   rx;
  logic signed [35:0]   ry;
  logic                 sat_xh, sat_xl, sat_yh, sat_yl;
  localparam logic signed [35:0] MAXV = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] MINV = -36'sh0_8000_0000;

  assign rx_s   = (cc[CORDIC_STAGES].x + VW'(128)) >>> 8;
  assign ry_s   = (cc[CORDIC_STAGES].y + VW'(128)) >>> 8;
  assign rx     = rx_s[35:0];
  assign ry     = ry_s[35:0];
  assign sat_xh = rx > MAXV;
  assign sat_xl = rx < MINV;
  assign sat_yh = ry > MAXV;
  assign sat_yl = ry < MINV;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd[D-1].pass) begin
        out_data.y_first  <= sd[D-1].xa;
        out_data.y_second <= sd[D-1].xb;
        out_data.clipped  <= 1'b0;
      end else begin
        out_data.y_first  <= sat_xh ? 32'sh7FFF_FFFF : (sat_xl ? 32'sh8000_0000 : rx[31:0]);
        out_data.y_second <= sat_yh ? 32'sh7FFF_FFFF : (sat_yl ? 32'sh8000_0000 : ry[31:0]);
        out_data.clipped  <= sat_xh || sat_xl || sat_yh || sat_yl;
      end
    end
  end

  `RPR_ASSERT(a_pass_item, clk, rst, (en && vl[D-1] && sd[D-1].pass) |=> (!out_data.clipped && out_data.y_first == $past(sd[D-1].xa)))
  `RPR_ASSERT(a_stall_holds, clk, rst, !en |=> $stable(vl))
  `RPR_ASSERT_NR(a_reset_empty, clk, rst |=> (!out_valid && vl == '0))
endmodule

/* test/tb_top.sv */
// Self-checking testbench for the rotary position rotate block.
`timescale 1ns / 1ps
module tb_top;
  import rpr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;
  localparam logic [3:0] ADDR_ROTARY_PAIRS = 4'd0;
  localparam logic [3:0] ADDR_FREQ_STEP    = 4'd4;
  localparam logic [3:0] ADDR_POS_SCALE    = 4'd8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rotary_position_rotate_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the block's registers, used by the predictor.
  logic [6:0]  sh_pairs = 7'd64;
  logic [27:0] sh_step  = 28'd3483400;
  logic [23:0] sh_scale = 24'd65536;
  // Q0.32 factors 2^(-2^-k) for the fractional exponent bits.
  logic [63:0] half_roots [EXP_BITS];

  in_t  pending_pairs [$];
  out_t rotated_pairs [$];
  int   errors = 0;
  bit   quiet = 1'b0;
  bit   in_fired = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   idle_cycles = 0;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= {64'd0, v}) r = t;
    end
    return r[63:0];
  endfunction

  function automatic longint fl_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] round_clip(input longint v, inout logic clip);
    longint r;
    r = fl_shift(v + 128, 8);
    if (r > 64'sd2147483647) begin
      r = 64'sd2147483647;
      clip = 1'b1;
    end
    if (r < -64'sd2147483648) begin
      r = -64'sd2147483648;
      clip = 1'b1;
    end
    return r[31:0];
  endfunction

  // Expected result of one pair under the current register values.
  function automatic out_t rotate_pair(input in_t it);
    out_t        res;
    int          lim;
    logic [63:0] e;
    int          n;
    logic [23:0] f;
    logic [95:0] m;
    logic [127:0] prod;
    logic [63:0] rad;
    logic [63:0] turns;
    logic [31:0] ang;
    longint      x, y, z, dx, dy;
    logic        clip;
    res = '0;
    clip = 1'b0;
    lim = (sh_pairs > 64) ? 64 : sh_pairs;
    if (it.pair_index >= lim) begin
      res.y_first  = it.x_first;
      res.y_second = it.x_second;
      return res;
    end
    e = it.pair_index * sh_step;
    n = int'(e >> EXP_BITS);
    f = e[23:0];
    m = 96'd1 << 32;
    for (int k = 1; k <= EXP_BITS; k++)
      if (f[EXP_BITS - k]) m = (m * half_roots[k - 1]) >> 32;
    prod = ({112'd0, it.position} * sh_scale) * m;
    rad = (n + 24 >= 128) ? 64'd0 : 64'(prod >> (n + 24));
    turns = rad * 64'h28BE60DC;
    ang = turns[55:24];
    x = fl_shift(longint'(it.x_first) * 64'sh9B74EDA8, 24);
    y = fl_shift(longint'(it.x_second) * 64'sh9B74EDA8, 24);
    // Second and third quadrants fold back by half a turn.
    if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
      x = -x;
      y = -y;
      ang = ang - 32'h80000000;
    end
    z = longint'($signed(ang));
    for (int k = 0; k < 24; k++) begin
      dx = fl_shift(y, k);
      dy = fl_shift(x, k);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[k]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[k]);
      end
    end
    res.y_first  = round_clip(x, clip);
    res.y_second = round_clip(y, clip);
    res.clipped  = clip;
    return res;
  endfunction

  // Input driver: one item per free slot, with random gaps.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fired)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_data <= pending_pairs.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 4);
      end
    end
  end

  // Monitor: predict on input accept, check on output accept, watchdog.
  always @(posedge clk) begin
    out_t want;
    in_fired <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) rotated_pairs.push_back(rotate_pair(in_data));
      if (out_valid && out_ready) begin
        if (rotated_pairs.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          want = rotated_pairs.pop_front();
          if (want.y_first !== out_data.y_first) begin
            $display("%0t: y_first expected %h actual %h", $time, want.y_first,
                     out_data.y_first);
            errors++;
          end
          if (want.y_second !== out_data.y_second) begin
            $display("%0t: y_second expected %h actual %h", $time, want.y_second,
                     out_data.y_second);
            errors++;
          end
          if (want.clipped !== out_data.clipped) begin
            $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                     out_data.clipped);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Register write through the configuration port: setup phase, then access phase.
  task automatic reg_write(input logic [3:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_regs(input logic [6:0] pairs, input logic [27:0] step,
                          input logic [23:0] scale);
    reg_write(ADDR_ROTARY_PAIRS, {25'd0, pairs});
    reg_write(ADDR_FREQ_STEP, {4'd0, step});
    reg_write(ADDR_POS_SCALE, {8'd0, scale});
    sh_pairs = pairs;
    sh_step  = step;
    sh_scale = scale;
  endtask

  // Wait until every queued item is out and checked, then let the pipeline settle.
  task automatic drain();
    while (pending_pairs.size() > 0 || in_valid || rotated_pairs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_t random_pair(input int max_idx);
    in_t it;
    it.pair_index = $urandom_range(0, 9) == 0 ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, max_idx));
    case ($urandom_range(0, 5))
      0: it.position = 16'hFFFF;
      1: it.position = 16'($urandom_range(0, 15));
      default: it.position = 16'($urandom);
    endcase
    // Mix full-range values, which clip often, with moderate ones.
    if ($urandom_range(0, 2) == 0) begin
      it.x_first  = $urandom;
      it.x_second = $urandom;
    end else begin
      it.x_first  = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
      it.x_second = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
    end
    return it;
  endfunction

  initial begin
    in_t it;
    logic [6:0]  pairs_list [8] = '{7'd64, 7'd1, 7'd32, 7'd0, 7'd127, 7'd17, 7'd64, 7'd64};
    logic [27:0] step_list  [8] = '{28'd3483400, 28'hFFFFFFF, 28'd0, 28'd3483400,
                                    28'd1234567, 28'd16777216, 28'd250000, 28'd3483400};
    logic [23:0] scale_list [8] = '{24'd65536, 24'd1, 24'hFFFFFF, 24'd65536,
                                    24'd0, 24'd32768, 24'd600000, 24'd65536};
    half_roots[0] = int_sqrt(64'h8000_0000_0000_0000);
    for (int k = 1; k < EXP_BITS; k++) half_roots[k] = int_sqrt(half_roots[k - 1] << 32);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items under the reset register values: extreme indexes,
    // positions and values, and a zero pair.
    for (int i = 0; i < 20; i++) begin
      it.pair_index = (i % 4 == 0) ? 6'd0 : (i % 4 == 1) ? 6'd63 : 6'(i);
      it.position   = (i % 3 == 0) ? 16'd0 : (i % 3 == 1) ? 16'hFFFF : 16'(i * 977);
      case (i % 5)
        0: begin it.x_first = 32'sh7FFFFFFF; it.x_second = 32'sh7FFFFFFF; end
        1: begin it.x_first = 32'sh80000000; it.x_second = 32'sh7FFFFFFF; end
        2: begin it.x_first = 32'sh80000000; it.x_second = 32'sh80000000; end
        3: begin it.x_first = 32'sh00010000; it.x_second = -32'sh00010000; end
        default: begin it.x_first = 32'sd0; it.x_second = 32'sd0; end
      endcase
      pending_pairs.push_back(it);
    end
    drain();

    // Random phases over several register settings; the last runs without gaps.
    for (int p = 0; p < 8; p++) begin
      set_regs(pairs_list[p], step_list[p], scale_list[p]);
      quiet = (p == 7);
      for (int i = 0; i < 200; i++)
        pending_pairs.push_back(random_pair(pairs_list[p] == 0 ? 63 :
                                            pairs_list[p] > 64 ? 63 : pairs_list[p] - 1));
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* rotary_position_rotate_top.f */
+incdir+src
src/rpr_pkg.sv
src/rpr_cfg.sv
src/rpr_root_cell.sv
src/rpr_cordic_cell.sv
src/rotary_position_rotate_top.sv
test/tb_top.sv
